/* rtl/cdq_pkg.sv */
// Shared types and constants for the circular deque unit.
package cdq_pkg;

  localparam int unsigned DEFAULT_DEPTH = 128;
  localparam int unsigned DATA_W        = 32;

  localparam logic [DATA_W-1:0] EMPTY_WORD = '1;
  localparam logic [DATA_W-1:0] ZERO_WORD  = '0;

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Outcome of one accepted operation, handed from pointer logic to the result stage
  typedef struct packed {
    logic    is_read;
    status_e status;
  } op_info_t;

endpackage

/* rtl/cdq_ram.sv */
// Single-port word store with registered read data.
module cdq_ram import cdq_pkg::*; #(
  parameter int unsigned DEPTH = DEFAULT_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cdq_ptr.sv */
// Front/rear indices, entry count and per-operation store access decisions.
module cdq_ptr import cdq_pkg::*; #(
  parameter int unsigned DEPTH = DEFAULT_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  func_e             func_i,
  input  logic [DATA_W-1:0] data_in_i,
  output logic              mem_we_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_addr_o,
  output logic [DATA_W-1:0] mem_wdata_o,
  output op_info_t          op_o
);

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          full, empty;

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : i - AW'(1);
  endfunction

  assign full        = (cnt_q == FULL_CNT);
  assign empty       = (cnt_q == '0);
  assign mem_wdata_o = data_in_i;

  always_comb begin
    head_d         = head_q;
    tail_d         = tail_q;
    cnt_d          = cnt_q;
    mem_we_o       = 1'b0;
    mem_re_o       = 1'b0;
    mem_addr_o     = head_q;
    op_o.is_read   = 1'b0;
    op_o.status    = STATUS_DONE;
    if (accept_i) begin
      case (func_i)
        FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
          if (full) begin
            op_o.status = STATUS_FULL;
          end else begin
            mem_we_o = 1'b1;
            cnt_d    = cnt_q + ONE_CNT;
            if (empty) begin
              // first word always lands in entry zero
              head_d     = '0;
              tail_d     = '0;
              mem_addr_o = '0;
            end else if (func_i == FUNC_PUSH_FRONT) begin
              head_d     = idx_prev(head_q);
              mem_addr_o = head_d;
            end else begin
              tail_d     = idx_next(tail_q);
              mem_addr_o = tail_d;
            end
          end
        end
        FUNC_POP_FRONT, FUNC_POP_BACK: begin
          if (empty) begin
            op_o.status = STATUS_EMPTY;
          end else begin
            mem_re_o     = 1'b1;
            op_o.is_read = 1'b1;
            cnt_d        = cnt_q - ONE_CNT;
            if (func_i == FUNC_POP_FRONT) begin
              mem_addr_o = head_q;
              head_d     = idx_next(head_q);
            end else begin
              mem_addr_o = tail_q;
              tail_d     = idx_prev(tail_q);
            end
            // drop to the reset pointers once the last word leaves
            if (cnt_q == ONE_CNT) begin
              head_d = '0;
              tail_d = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* rtl/circular_deque_unit.sv */
// Top level of the circular deque: stream ports, pointer logic, store and result register.
//
//  channel   direction  tdata               tuser
//  s_axis    in         data_in [31:0]      func [1:0]
//  m_axis    out        data_out [31:0]     status [1:0]
//
//  Inserts and refused operations show their result in the cycle after the transaction.
//  Removals first read the store, then the result register loads the word.
//  A new operation is taken when no store read is pending and the result register is
//  empty or being drained: inserts can run one per cycle, removals wait out their read.
//  Reset clears the indices and count (deque empty); the store needs no clearing.
//  A stalled result holds in the output register and stops further input.
module circular_deque_unit import cdq_pkg::*; #(
  parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [DATA_W-1:0] s_axis_tdata_i,  // [31:0] data_in
  input  logic [1:0]        s_axis_tuser_i,  // [1:0] func
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [DATA_W-1:0] m_axis_tdata_o,  // [31:0] data_out
  output logic [1:0]        m_axis_tuser_o   // [1:0] status
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic              accept;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;
  op_info_t          op;

  logic              rd_pend_q, rd_pend_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  status_e           out_status_q, out_status_d;

  assign s_axis_tready_o = !rd_pend_q && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  cdq_ptr #(
    .DEPTH (DEPTH)
  ) u_ptr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_e'(s_axis_tuser_i)),
    .data_in_i   (s_axis_tdata_i),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .op_o        (op)
  );

  cdq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    rd_pend_d    = 1'b0;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    if (rd_pend_q) begin
      out_valid_d  = 1'b1;
      out_data_d   = mem_rdata;
      out_status_d = STATUS_DONE;
    end else if (accept) begin
      if (op.is_read) begin
        // wait for the store word, which arrives in the next cycle
        rd_pend_d = 1'b1;
      end else begin
        out_valid_d  = 1'b1;
        out_status_d = op.status;
        out_data_d   = (op.status == STATUS_EMPTY) ? EMPTY_WORD : ZERO_WORD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

/* rtl/cdq_checker.sv */
// Port-level checks for the circular deque unit, bound to the top level.
module cdq_checker import cdq_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic [1:0]        s_axis_tuser_i,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [DATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]        m_axis_tuser_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == STATUS_EMPTY) |-> m_axis_tdata_o == EMPTY_WORD)
    else $error("empty refusal without all-ones word");

  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == STATUS_FULL) |-> m_axis_tdata_o == ZERO_WORD)
    else $error("full refusal with nonzero word");

  // an insert transaction never reports an empty refusal in the next cycle
  a_insert_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o &&
      ((s_axis_tuser_i == FUNC_PUSH_FRONT) || (s_axis_tuser_i == FUNC_PUSH_BACK)) |=>
      m_axis_tvalid_o &&
        ((m_axis_tuser_o == STATUS_DONE) || (m_axis_tuser_o == STATUS_FULL)))
    else $error("insert produced a bad result");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
